// ----- rtl/ncd_pkg.sv -----
`default_nettype none

package ncd_pkg;

	// Fixed field widths of the channels and config registers
	localparam int NODE_IDX_W  = 4;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int NODE_CNT_W  = 5;
	localparam int ALPHA_W     = 9;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = CFG_IDX_W'(1);

	// Reset values and Q8 unity
	localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = NODE_CNT_W'(16);
	localparam logic [ALPHA_W-1:0]    ALPHA_RST      = ALPHA_W'(77);
	localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = ALPHA_W'(256);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQ,
		ST_SCAN,
		ST_WR
	} ncd_state_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic wr_en;
		logic new_node;
	} ncd_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/ncd_if.sv -----
`default_nettype none

interface ncd_query_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] rect_x_low;
	logic signed [COORD_BITS-1:0] rect_y_low;
	logic signed [COORD_BITS-1:0] rect_x_high;
	logic signed [COORD_BITS-1:0] rect_y_high;

	modport source (
		output valid, rect_x_low, rect_y_low, rect_x_high, rect_y_high,
		input  ready
	);
	modport sink (
		input  valid, rect_x_low, rect_y_low, rect_x_high, rect_y_high,
		output ready
	);
endinterface

interface ncd_result_if;
	logic                           valid;
	logic                           ready;
	logic [ncd_pkg::NODE_IDX_W-1:0] node_index;
	logic                           new_node;

	modport source (
		output valid, node_index, new_node,
		input  ready
	);
	modport sink (
		input  valid, node_index, new_node,
		output ready
	);
endinterface

interface ncd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ncd_pkg::CFG_IDX_W-1:0]  index;
	logic [ncd_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/ncd_cell.sv -----
`default_nettype none

module ncd_cell #(
	parameter int COORD_BITS = 24,
	parameter int IDX_W      = 4,
	parameter int CELL_IDX   = 0
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    active,
	input  wire  signed [COORD_BITS-1:0]           q_x,
	input  wire  signed [COORD_BITS-1:0]           q_y,
	input  wire  signed [COORD_BITS+9:0]           qa_x,
	input  wire  signed [COORD_BITS+9:0]           qa_y,
	input  wire         [ncd_pkg::ALPHA_W-1:0]     a_inv,
	input  ncd_pkg::ncd_ctl_t                      ctl,
	input  wire         [IDX_W-1:0]                sel_idx,
	input  wire                                    tin_have,
	input  wire                                    tin_found,
	input  wire         [2*COORD_BITS+2:0]         tin_dist,
	input  wire         [IDX_W-1:0]                tin_idx,
	output logic                                   tout_have_q,
	output logic                                   tout_found_q,
	output logic        [2*COORD_BITS+2:0]         tout_dist_q,
	output logic        [IDX_W-1:0]                tout_idx_q
);
	import ncd_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int SQ_W = 2*C + 2;
	localparam int D_W  = SQ_W + 1;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic signed [C-1:0]    cx_q, cy_q;
	logic                   seen_q;
	logic        [SQ_W-1:0] sqx_q, sqy_q;
	logic signed [C+9:0]    cbx_q, cby_q;

	logic signed [C:0]      dx, dy;
	logic signed [SQ_W-1:0] px, py;
	logic signed [C+9:0]    cbx, cby;
	logic signed [C+10:0]   emax, emay;
	logic        [D_W-1:0]  sq_sum;
	logic                   mine;

	assign dx     = {q_x[C-1], q_x} - {cx_q[C-1], cx_q};
	assign dy     = {q_y[C-1], q_y} - {cy_q[C-1], cy_q};
	assign px     = dx * dx;
	assign py     = dy * dy;
	assign cbx    = cx_q * $signed({1'b0, a_inv});
	assign cby    = cy_q * $signed({1'b0, a_inv});
	assign emax   = {qa_x[C+9], qa_x} + {cbx_q[C+9], cbx_q};
	assign emay   = {qa_y[C+9], qa_y} + {cby_q[C+9], cby_q};
	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign mine   = ctl.wr_en && (sel_idx == MY_IDX);

	// squares and weighted center run every cycle; inputs hold during a scan
	always_ff @(posedge clk) begin
		sqx_q <= $unsigned(px);
		sqy_q <= $unsigned(py);
		cbx_q <= cbx;
		cby_q <= cby;
		if (mine) begin
			if (ctl.new_node) begin
				cx_q <= q_x;
				cy_q <= q_y;
			end else begin
				cx_q <= emax[C+7:8];
				cy_q <= emay[C+7:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (mine && ctl.new_node) begin
			seen_q <= 1'b1;
		end
	end

	// running best handed to the next cell
	always_ff @(posedge clk) begin
		if (active && !tin_found && !seen_q) begin
			tout_have_q  <= tin_have;
			tout_found_q <= 1'b1;
			tout_dist_q  <= tin_dist;
			tout_idx_q   <= MY_IDX;
		end else if (active && !tin_found && (!tin_have || (sq_sum < tin_dist))) begin
			tout_have_q  <= 1'b1;
			tout_found_q <= tin_found;
			tout_dist_q  <= sq_sum;
			tout_idx_q   <= MY_IDX;
		end else begin
			tout_have_q  <= tin_have;
			tout_found_q <= tin_found;
			tout_dist_q  <= tin_dist;
			tout_idx_q   <= tin_idx;
		end
	end

`ifndef NO_ASSERTIONS
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seen_q))
		else $error("seen mark cleared outside reset");

	a_ema_on_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(mine && !ctl.new_node) |-> seen_q)
		else $error("center update on a node never seen");

	a_found_kept: assert property (@(posedge clk) disable iff (!arst_n)
		tin_found |=> (tout_found_q && (tout_idx_q == $past(tin_idx))))
		else $error("unseen pick overridden downstream");
`endif

endmodule

`default_nettype wire

// ----- rtl/nearest_center_ema_dispatcher.sv -----
`default_nettype none

// Channel   Dir  Beat contents
// query     in   rect_x_low, rect_y_low, rect_x_high, rect_y_high
// result    out  node_index, new_node
// cfg       in   index (0 node_count, 1 alpha_q8), data
//
// A query runs through accept, square, a step of the best-so-far token
// through each node cell of the row, then the center write. The result
// sits in an output register; the next query is taken while it waits,
// but the write step holds until that register is free. arst_n clears
// seen marks, configuration, control and the result valid flag; centers
// have no reset. cfg is always ready; the user must write it only while
// no query is in flight, as the block itself does not enforce this.

module nearest_center_ema_dispatcher #(
	parameter int MAX_NODES  = 16,
	parameter int COORD_BITS = 24
) (
	input  wire           clk,
	input  wire           arst_n,
	ncd_query_if.sink     query,
	ncd_result_if.source  result,
	ncd_cfg_if.sink       cfg
);
	import ncd_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int D_W   = 2*C + 3;
	localparam int PAD_W = IDX_W + NODE_IDX_W;

	// configuration
	logic [NODE_CNT_W-1:0] node_count_q;
	logic [ALPHA_W-1:0]    alpha_q;

	// sequencer
	ncd_state_t       state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             in_ready;
	logic             wr_fire;
	ncd_ctl_t         ctl;

	// query center and its alpha-weighted term
	logic signed [C-1:0]  qx_q, qy_q;
	logic signed [C:0]    sum_x, sum_y;
	logic signed [C+9:0]  qa_x_q, qa_y_q;
	logic [ALPHA_W-1:0]   a_eff, a_inv;

	// token chain through the cells
	logic [MAX_NODES:0] tok_have, tok_found;
	logic [D_W-1:0]     tok_dist [MAX_NODES+1];
	logic [IDX_W-1:0]   tok_idx  [MAX_NODES+1];
	logic [MAX_NODES-1:0] active;

	// output register
	logic                  out_valid_q;
	logic [NODE_IDX_W-1:0] out_idx_q;
	logic                  out_new_q;
	logic [PAD_W-1:0]      idx_pad;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			alpha_q      <= ALPHA_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_NODE_COUNT) begin
				node_count_q <= cfg.data[NODE_CNT_W-1:0];
			end else if (cfg.index == REG_ALPHA) begin
				alpha_q <= cfg.data[ALPHA_W-1:0];
			end
		end
	end

	// alpha above unity saturates
	assign a_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign a_inv = ALPHA_ONE - a_eff;

	// floor of the midpoint: arithmetic shift of the widened sum
	assign sum_x = {query.rect_x_low[C-1], query.rect_x_low}
		+ {query.rect_x_high[C-1], query.rect_x_high};
	assign sum_y = {query.rect_y_low[C-1], query.rect_y_low}
		+ {query.rect_y_high[C-1], query.rect_y_high};

	always_ff @(posedge clk) begin
		if (query.valid && in_ready) begin
			qx_q <= sum_x[C:1];
			qy_q <= sum_y[C:1];
		end
		qa_x_q <= qx_q * $signed({1'b0, a_eff});
		qa_y_q <= qy_q * $signed({1'b0, a_eff});
	end

	// node count of zero acts as one; counts past the row saturate naturally
	genvar gi;
	generate
		for (gi = 0; gi < MAX_NODES; gi++) begin : g_cell
			assign active[gi] = (node_count_q == '0) ? (gi == 0)
				: (32'(node_count_q) > 32'(gi));

			ncd_cell #(
				.COORD_BITS (COORD_BITS),
				.IDX_W      (IDX_W),
				.CELL_IDX   (gi)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.active       (active[gi]),
				.q_x          (qx_q),
				.q_y          (qy_q),
				.qa_x         (qa_x_q),
				.qa_y         (qa_y_q),
				.a_inv        (a_inv),
				.ctl          (ctl),
				.sel_idx      (tok_idx[MAX_NODES]),
				.tin_have     (tok_have[gi]),
				.tin_found    (tok_found[gi]),
				.tin_dist     (tok_dist[gi]),
				.tin_idx      (tok_idx[gi]),
				.tout_have_q  (tok_have[gi+1]),
				.tout_found_q (tok_found[gi+1]),
				.tout_dist_q  (tok_dist[gi+1]),
				.tout_idx_q   (tok_idx[gi+1])
			);
		end
	endgenerate

	// empty token enters the head of the row
	assign tok_have[0]  = 1'b0;
	assign tok_found[0] = 1'b0;
	assign tok_dist[0]  = '0;
	assign tok_idx[0]   = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		wr_fire      = 1'b0;
		ctl.wr_en    = 1'b0;
		ctl.new_node = tok_found[MAX_NODES];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (query.valid) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == IDX_W'(MAX_NODES - 1)) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				// tail token holds the pick; write the cell and the result together
				if (!out_valid_q || result.ready) begin
					wr_fire   = 1'b1;
					ctl.wr_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign query.ready = in_ready;

	assign idx_pad = PAD_W'(tok_idx[MAX_NODES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			out_idx_q <= idx_pad[NODE_IDX_W-1:0];
			out_new_q <= tok_found[MAX_NODES];
		end
	end

	assign result.valid      = out_valid_q;
	assign result.node_index = out_idx_q;
	assign result.new_node   = out_new_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> (state_q == ST_SQ))
		else $error("accepted query did not start a scan");

	a_result_from_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WR))
		else $error("result beat not produced by the write step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_fire && out_valid_q) |-> result.ready)
		else $error("pending result overwritten");

	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (tok_found[MAX_NODES] || tok_have[MAX_NODES]))
		else $error("scan ended without a pick");
`endif

endmodule

`default_nettype wire
